@@ sv/dspc_pkg.sv @@
package dspc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] REG_LOOP_ENABLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IRQ_ENABLE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PERIOD_RELOAD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_START_PAGE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LENGTH_CODE   = 3'd4;

  localparam logic [15:0] SAMPLE_BASE = 16'hC000;
  localparam logic [15:0] WRAP_ADDR   = 16'h8000;
  localparam logic [6:0]  LEVEL_TOP   = 7'd125;
  localparam logic [6:0]  LEVEL_MASK  = 7'h7F;
  localparam logic [3:0]  LENGTH_LSB  = 4'h1;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_FETCH  = 3'd1,
    CMD_LEVEL  = 3'd2,
    CMD_ENABLE = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_e;

  typedef struct packed {
    logic       loop_enable;
    logic       irq_enable;
    logic [9:0] period_reload;
    logic [7:0] start_page;
    logic [7:0] length_code;
  } cfg_t;

  typedef struct packed {
    logic [10:0] rate_counter;
    logic [6:0]  level;
    logic [7:0]  bit_shifter;
    logic [3:0]  bits_left;
    logic        silent;
    logic [7:0]  byte_buffer;
    logic        buffer_empty;
    logic [15:0] reader_address;
    logic [11:0] bytes_left;
    logic        irq_pend;
    logic        channel_on;
    logic        fetch_pending;
  } state_t;

  function automatic logic [15:0] start_address(input logic [7:0] page);
    return SAMPLE_BASE | {2'b00, page, 6'b000000};
  endfunction

  function automatic logic [11:0] sample_bytes(input logic [7:0] code);
    return {code, LENGTH_LSB};
  endfunction

  function automatic state_t reset_state();
    state_t s;
    s = '0;
    s.silent       = 1'b1;
    s.buffer_empty = 1'b1;
    return s;
  endfunction

endpackage

@@ sv/dspc_step.sv @@
module dspc_step (
  input  dspc_pkg::state_t st_i,
  input  dspc_pkg::cfg_t   cfg_i,
  input  logic [2:0]       cmd_i,
  input  logic [7:0]       data_i,
  output dspc_pkg::state_t st_o
);
  import dspc_pkg::*;

  state_t      nx;
  logic [15:0] addr_inc;

  assign addr_inc = st_i.reader_address + 16'd1;

  always_comb begin
    nx = st_i;
    case (cmd_e'(cmd_i))
      CMD_TICK: begin
        if (st_i.channel_on) begin
          if (st_i.rate_counter == 11'd0) begin
            nx.rate_counter = {1'b0, cfg_i.period_reload} + 11'd1;
            if (!st_i.silent) begin
              if (st_i.bit_shifter[0]) begin
                if (st_i.level <= LEVEL_TOP) nx.level = st_i.level + 7'd2;
              end else if (st_i.level >= 7'd2) begin
                nx.level = st_i.level - 7'd2;
              end
              nx.bit_shifter = {1'b0, st_i.bit_shifter[7:1]};
            end
            if (st_i.bits_left <= 4'd1) begin
              nx.bits_left = 4'd8;
              if (st_i.buffer_empty) begin
                nx.silent = 1'b1;
              end else begin
                nx.silent        = 1'b0;
                nx.bit_shifter   = st_i.byte_buffer;
                nx.buffer_empty  = 1'b1;
                nx.fetch_pending = 1'b1;
              end
            end else begin
              nx.bits_left = st_i.bits_left - 4'd1;
            end
          end else begin
            nx.rate_counter = st_i.rate_counter - 11'd1;
          end
        end
      end
      CMD_FETCH: begin
        nx.fetch_pending = 1'b0;
        if (st_i.bytes_left != 12'd0) begin
          nx.byte_buffer    = data_i;
          nx.buffer_empty   = 1'b0;
          nx.reader_address = (addr_inc == 16'd0) ? WRAP_ADDR : addr_inc;
          nx.bytes_left     = st_i.bytes_left - 12'd1;
          if (st_i.bytes_left == 12'd1) begin
            if (cfg_i.loop_enable) begin
              nx.reader_address = start_address(cfg_i.start_page);
              nx.bytes_left     = sample_bytes(cfg_i.length_code);
            end else if (cfg_i.irq_enable) begin
              nx.irq_pend = 1'b1;
            end
          end
        end
      end
      CMD_LEVEL: begin
        nx.level = data_i[6:0] & LEVEL_MASK;
      end
      CMD_ENABLE: begin
        nx.irq_pend   = 1'b0;
        nx.channel_on = data_i[4];
        if (data_i[4] && st_i.buffer_empty) nx.fetch_pending = 1'b1;
      end
      CMD_STATUS: begin
        nx.irq_pend = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign st_o = nx;

endmodule

@@ sv/delta_sample_playback_channel.sv @@
// One-bit delta sample playback channel. Commands (tick, fetched byte, direct
// level, enable write, status read) enter on the input channel; each accepted
// item yields exactly one result item holding the level, fetch request, fetch
// address and irq flag as they stand after the command. The block takes one
// item per clock: an input register feeds update logic that writes the
// channel state (held during a config write) and the result register
// together, and input ready drops only while a full input register waits
// behind a result that is not being taken. Configuration writes are always
// ready; writing period, start page or length also loads the rate counter,
// reader address or byte count. No clearing pass is needed after reset.
module delta_sample_playback_channel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dspc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dspc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      command_i,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [6:0]                      dac_level_o,
  output logic                            fetch_request_o,
  output logic [15:0]                     fetch_address_o,
  output logic                            irq_o
);
  import dspc_pkg::*;

  cfg_t        cfg_q;
  state_t      st_q, st_d;
  logic        s1_valid_q;
  logic [2:0]  s1_cmd_q;
  logic [7:0]  s1_data_q;
  logic        out_valid_q;
  logic [6:0]  level_q;
  logic        fetch_req_q;
  logic [15:0] fetch_addr_q;
  logic        irq_q;
  logic        advance;
  logic        cfg_we;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_we     = cfg_valid_i && cfg_ready_o;

  dspc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .cmd_i  (s1_cmd_q),
    .data_i (s1_data_q),
    .st_o   (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      st_q        <= reset_state();
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_i)
          REG_LOOP_ENABLE:   cfg_q.loop_enable <= cfg_data_i[0];
          REG_IRQ_ENABLE:    cfg_q.irq_enable  <= cfg_data_i[0];
          REG_PERIOD_RELOAD: begin
            cfg_q.period_reload <= cfg_data_i;
            st_q.rate_counter   <= {1'b0, cfg_data_i};
          end
          REG_START_PAGE: begin
            cfg_q.start_page    <= cfg_data_i[7:0];
            st_q.reader_address <= start_address(cfg_data_i[7:0]);
          end
          REG_LENGTH_CODE: begin
            cfg_q.length_code <= cfg_data_i[7:0];
            st_q.bytes_left   <= sample_bytes(cfg_data_i[7:0]);
          end
          default: begin
          end
        endcase
      end else if (advance && s1_valid_q) begin
        st_q <= st_d;
      end
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q  <= command_i;
      s1_data_q <= data_byte_i;
    end
    if (advance && s1_valid_q) begin
      level_q      <= st_d.level & LEVEL_MASK;
      fetch_req_q  <= st_d.fetch_pending && (st_d.bytes_left != 12'd0);
      fetch_addr_q <= st_d.reader_address;
      irq_q        <= st_d.irq_pend;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dac_level_o     = level_q;
  assign fetch_request_o = fetch_req_q;
  assign fetch_address_o = fetch_addr_q;
  assign irq_o           = irq_q;

endmodule

@@ sv/dspc_checker.sv @@
module dspc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [6:0]                    dac_level_o,
  input logic                          fetch_request_o,
  input logic [15:0]                   fetch_address_o,
  input logic                          irq_o
);

  // result valid holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(dac_level_o) && $stable(fetch_request_o)
      && $stable(fetch_address_o) && $stable(irq_o))
    else $error("result payload changed while stalled");

  // input back-pressure only comes from a held result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("accepted item produced no result in time");

endmodule

bind delta_sample_playback_channel dspc_checker u_dspc_checker (.*);

@@ tb/sv/delta_sample_playback_channel_tb.sv @@
`timescale 1ns / 1ps

module delta_sample_playback_channel_tb;
  import dspc_pkg::*;

  localparam int unsigned ItemTarget = 1150;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 160;
  localparam int unsigned IdlePct    = 15;
  localparam logic [2:0]  CMD_FIRST_UNUSED = 3'(CMD_STATUS) + 3'd1;
  localparam logic [2:0]  CMD_LAST_CODE    = '1;

  typedef struct packed {
    logic [6:0]  level;
    logic        fetch_request;
    logic [15:0] fetch_address;
    logic        irq;
  } chan_status_t;

  class delta_channel_mirror;
    cfg_t         cfg;
    state_t       st;
    chan_status_t status_q[$];
    int           errors;

    function new();
      cfg = '0;
      st = '0;
      st.silent = 1'b1;
      st.buffer_empty = 1'b1;
      errors = 0;
    endfunction

    function logic [15:0] first_byte_addr();
      return SAMPLE_BASE | (16'(cfg.start_page) << 6);
    endfunction

    function logic fetch_wanted();
      return st.fetch_pending && (st.bytes_left != '0);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_LOOP_ENABLE: cfg.loop_enable = val[0];
        REG_IRQ_ENABLE: cfg.irq_enable = val[0];
        REG_PERIOD_RELOAD: begin
          cfg.period_reload = val[9:0];
          st.rate_counter = {1'b0, val[9:0]};
        end
        REG_START_PAGE: begin
          cfg.start_page = val[7:0];
          st.reader_address = first_byte_addr();
        end
        REG_LENGTH_CODE: begin
          cfg.length_code = val[7:0];
          st.bytes_left = {val[7:0], 4'h1};
        end
        default: ;
      endcase
    endfunction

    function void shift_out_bit();
      if (!st.silent) begin
        if (st.bit_shifter[0]) begin
          if (st.level <= LEVEL_TOP) st.level = st.level + 7'd2;
        end else begin
          if (st.level >= 7'd2) st.level = st.level - 7'd2;
        end
        st.bit_shifter = st.bit_shifter >> 1;
      end
      if (st.bits_left <= 4'd1) begin
        st.bits_left = 4'd8;
        if (st.buffer_empty) begin
          st.silent = 1'b1;
        end else begin
          st.silent = 1'b0;
          st.bit_shifter = st.byte_buffer;
          st.buffer_empty = 1'b1;
          st.fetch_pending = 1'b1;
        end
      end else begin
        st.bits_left = st.bits_left - 4'd1;
      end
    endfunction

    function void load_byte(logic [7:0] b);
      st.fetch_pending = 1'b0;
      if (st.bytes_left == '0) return;
      st.byte_buffer = b;
      st.buffer_empty = 1'b0;
      st.reader_address = st.reader_address + 16'd1;
      if (st.reader_address == '0) st.reader_address = WRAP_ADDR;
      st.bytes_left = st.bytes_left - 12'd1;
      if (st.bytes_left == '0) begin
        if (cfg.loop_enable) begin
          st.reader_address = first_byte_addr();
          st.bytes_left = {cfg.length_code, 4'h1};
        end else if (cfg.irq_enable) begin
          st.irq_pend = 1'b1;
        end
      end
    endfunction

    function void take_command(logic [2:0] cmd, logic [7:0] data);
      chan_status_t s;
      case (cmd)
        CMD_TICK: begin
          if (st.channel_on) begin
            if (st.rate_counter == '0) begin
              st.rate_counter = 11'(cfg.period_reload) + 11'd1;
              shift_out_bit();
            end else begin
              st.rate_counter = st.rate_counter - 11'd1;
            end
          end
        end
        CMD_FETCH: load_byte(data);
        CMD_LEVEL: st.level = data[6:0] & LEVEL_MASK;
        CMD_ENABLE: begin
          st.irq_pend = 1'b0;
          st.channel_on = data[4];
          if (st.channel_on && st.buffer_empty) st.fetch_pending = 1'b1;
        end
        CMD_STATUS: st.irq_pend = 1'b0;
        default: ;
      endcase
      s.level = st.level;
      s.fetch_request = fetch_wanted();
      s.fetch_address = st.reader_address;
      s.irq = st.irq_pend;
      status_q.push_back(s);
    endfunction

    function void compare_status(logic [6:0] lvl, logic req, logic [15:0] addr, logic irq);
      chan_status_t want;
      if (status_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      want = status_q.pop_front();
      if (lvl !== want.level) begin
        $error("dac_level: expected %0d, got %0d", want.level, lvl);
        errors++;
      end
      if (req !== want.fetch_request) begin
        $error("fetch_request: expected %0d, got %0d", want.fetch_request, req);
        errors++;
      end
      if (addr !== want.fetch_address) begin
        $error("fetch_address: expected %h, got %h", want.fetch_address, addr);
        errors++;
      end
      if (irq !== want.irq) begin
        $error("irq: expected %0d, got %0d", want.irq, irq);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          command_i = '0;
  logic [7:0]          data_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [6:0]          dac_level_o;
  logic                fetch_request_o;
  logic [15:0]         fetch_address_o;
  logic                irq_o;

  delta_channel_mirror sb;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        calm = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;

  delta_sample_playback_channel uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dac_level_o    (dac_level_o),
    .fetch_request_o(fetch_request_o),
    .fetch_address_o(fetch_address_o),
    .irq_o          (irq_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.compare_status(dac_level_o, fetch_request_o, fetch_address_o, irq_o);
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [7:0] data);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_command(cmd, data);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] sample_byte();
    case ($urandom_range(2))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned plen;
    int unsigned kind;
    int unsigned r;
    logic [7:0]  d;
    logic [CfgDataW-1:0] v;

    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, unused codes, level extremes, channel off
    send_item(CMD_STATUS, 8'h00);
    send_item(CMD_FIRST_UNUSED, 8'hFF);
    send_item(CMD_LAST_CODE, 8'h5A);
    send_item(CMD_LEVEL, 8'hFF);
    send_item(CMD_LEVEL, 8'h80);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_FETCH, 8'hA5);
    send_item(CMD_ENABLE, 8'hEF);
    wait_drained();

    // one-byte sample at the top page, irq on end
    write_reg(REG_LOOP_ENABLE, 10'h3FE);
    write_reg(REG_IRQ_ENABLE, 10'h001);
    write_reg(REG_PERIOD_RELOAD, 10'h000);
    write_reg(REG_START_PAGE, 10'h3FF);
    write_reg(REG_LENGTH_CODE, 10'h000);
    send_item(CMD_ENABLE, 8'h10);
    send_item(CMD_FETCH, 8'hFF);
    send_item(CMD_STATUS, 8'hFF);
    send_item(CMD_LEVEL, 8'h7C);
    repeat (10) send_item(CMD_TICK, 8'hFF);
    send_item(CMD_ENABLE, 8'h00);
    send_item(CMD_TICK, 8'h00);

    while (items_sent < ItemTarget) begin
      wait_drained();
      if ($urandom_range(9) < 7) write_reg(REG_LOOP_ENABLE, 10'($urandom));
      if ($urandom_range(9) < 7) write_reg(REG_IRQ_ENABLE, 10'($urandom));
      if ($urandom_range(9) < 7) begin
        r = $urandom_range(9);
        v = (r == 0) ? 10'h3FF : (r == 1) ? 10'($urandom) : 10'($urandom_range(3));
        write_reg(REG_PERIOD_RELOAD, v);
      end
      if ($urandom_range(9) < 7) begin
        r = $urandom_range(3);
        d = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom);
        write_reg(REG_START_PAGE, {2'($urandom), d});
      end
      if ($urandom_range(9) < 7) begin
        r = $urandom_range(5);
        d = (r == 0) ? 8'hFF : (r == 1) ? 8'($urandom) : 8'($urandom_range(4));
        write_reg(REG_LENGTH_CODE, {2'($urandom), d});
      end

      calm = (items_sent >= 700) && (items_sent < 900);
      if (items_sent >= 400) hold_request = 1'b1;

      r = $urandom_range(99);
      kind = (r < 60) ? 0 : (r < 85) ? 1 : 2;
      plen = (kind == 1) ? $urandom_range(160, 80) : $urandom_range(120, 40);
      if (kind != 2) begin
        d = 8'($urandom);
        d[4] = 1'b1;
        send_item(CMD_ENABLE, d);
      end

      repeat (plen) begin
        r = $urandom_range(99);
        if (kind == 2) begin
          send_item(3'($urandom), 8'($urandom));
        end else if (kind == 1) begin
          if (r < 55) send_item(CMD_FETCH, sample_byte());
          else if (r < 85) send_item(CMD_TICK, 8'($urandom));
          else if (r < 90) send_item(CMD_STATUS, 8'($urandom));
          else if (r < 95) send_item(CMD_LEVEL, 8'($urandom));
          else send_item(CMD_ENABLE, 8'($urandom) | 8'h10);
        end else if (sb.fetch_wanted() && r < 80) begin
          send_item(CMD_FETCH, sample_byte());
        end else if (r < 70) begin
          send_item(CMD_TICK, 8'($urandom));
        end else if (r < 78) begin
          d = 8'($urandom);
          d[4] = ($urandom_range(9) != 0);
          send_item(CMD_ENABLE, d);
        end else if (r < 86) begin
          send_item(CMD_LEVEL, 8'($urandom));
        end else if (r < 93) begin
          send_item(CMD_STATUS, 8'($urandom));
        end else if (r < 97) begin
          send_item(CMD_FETCH, sample_byte());
        end else begin
          send_item(3'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED)), 8'($urandom));
        end
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ delta_sample_playback_channel.f @@
sv/dspc_pkg.sv
sv/dspc_step.sv
sv/delta_sample_playback_channel.sv
sv/dspc_checker.sv
tb/sv/delta_sample_playback_channel_tb.sv
